/* hdl/register_pool_allocator_macros.svh */
// Assertion macros shared by the register pool allocator modules.
`ifndef REGISTER_POOL_ALLOCATOR_MACROS_SVH
`define REGISTER_POOL_ALLOCATOR_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define RPA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rpa_pkg.sv */
// Shared types and constants for the register pool allocator.
`default_nettype none

package rpa_pkg;

    localparam int NumRegs      = 32;
    localparam int RegLimit     = (NumRegs < 32) ? NumRegs : 32;
    localparam int RegBits      = 5;
    localparam int MaskBits     = 32;
    localparam int CountBits    = 6;
    localparam int TopBits      = $clog2(NumRegs + 1);
    localparam int StackAddrBits = $clog2(NumRegs);
    localparam int FillBits     = $clog2(RegLimit);
    localparam int CfgIdxBits   = 1;

    localparam logic [MaskBits-1:0] LowMask = (RegLimit >= 32) ? 32'hFFFF_FFFF :
        MaskBits'((64'd1 << RegLimit) - 64'd1);

    // request kinds
    localparam logic [2:0] KIND_ALLOC_TEMP = 3'd0;
    localparam logic [2:0] KIND_ALLOC_VAR  = 3'd1;
    localparam logic [2:0] KIND_RELEASE    = 3'd2;
    localparam logic [2:0] KIND_RESTART    = 3'd3;
    localparam logic [2:0] KIND_RAW_ADD    = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_FREE     = 3'd2;
    localparam logic [2:0] ST_NOTMEM   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxBits-1:0] CFG_TEMP_MEMBER_MASK = 1'b0;
    localparam logic [CfgIdxBits-1:0] CFG_VAR_MEMBER_MASK  = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [RegBits-1:0] reg_num;
        logic               target_pool;
    } t_req;

    typedef struct packed {
        logic [2:0]           status;
        logic [RegBits-1:0]   granted_reg;
        logic                 stolen;
        logic [MaskBits-1:0]  temp_used_mask;
        logic [MaskBits-1:0]  var_used_mask;
        logic [MaskBits-1:0]  standin_mask;
        logic [CountBits-1:0] temp_used_count;
        logic [CountBits-1:0] var_used_count;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_REPORT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic commit;
        logic fill_step;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_restart;
        logic fill_last;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/rpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/rpa_ctrl.sv */
// Sequencing controller for the register pool allocator.
`default_nettype none
`include "register_pool_allocator_macros.svh"

module rpa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    input  wire rpa_pkg::t_stat i_stat,
    output rpa_pkg::t_cmd      o_cmd
);

    rpa_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpa_pkg::S_IDLE: begin
                if (i_req_valid) n_state = rpa_pkg::S_EXEC;
            end
            rpa_pkg::S_EXEC: begin
                if (i_stat.is_restart) n_state = rpa_pkg::S_FILL;
                else if (out_free)     n_state = rpa_pkg::S_IDLE;
            end
            rpa_pkg::S_FILL: begin
                if (i_stat.fill_last) n_state = rpa_pkg::S_REPORT;
            end
            rpa_pkg::S_REPORT: begin
                if (out_free) n_state = rpa_pkg::S_IDLE;
            end
            default: n_state = rpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready     = 1'b0;
        o_cmd           = '0;
        case (r_state)
            rpa_pkg::S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            rpa_pkg::S_EXEC: begin
                o_cmd.commit   = i_stat.is_restart || out_free;
                o_cmd.load_out = !i_stat.is_restart && out_free;
            end
            rpa_pkg::S_FILL: begin
                o_cmd.fill_step = 1'b1;
            end
            rpa_pkg::S_REPORT: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out)  n_out_valid = 1'b1;
        else if (i_rsp_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    `RPA_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n, o_cmd.load_out, o_rsp_valid,
        "result load did not raise response valid")
    `RPA_ASSERT_NEXT(a_fill_runs_to_end, i_clk, i_rst_n,
        (r_state == rpa_pkg::S_FILL) && !i_stat.fill_last, r_state == rpa_pkg::S_FILL,
        "fill sweep left early")
    `RPA_ASSERT_NEXT(a_exec_waits_for_slot, i_clk, i_rst_n,
        (r_state == rpa_pkg::S_EXEC) && !i_stat.is_restart && !out_free,
        (r_state == rpa_pkg::S_EXEC) && o_rsp_valid,
        "execute step finished while the output slot was occupied")

endmodule

`default_nettype wire

/* hdl/rpa_datapath.sv */
// Pool state, stack memories and result register of the register pool allocator.
`default_nettype none
`include "register_pool_allocator_macros.svh"

module rpa_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rpa_pkg::t_req                      i_req,
    output rpa_pkg::t_rsp                           o_rsp,
    input  wire logic                               i_cfg_we,
    input  wire logic [rpa_pkg::CfgIdxBits-1:0]     i_cfg_idx,
    input  wire logic [rpa_pkg::MaskBits-1:0]       i_cfg_wdata,
    input  wire rpa_pkg::t_cmd                      i_cmd,
    output rpa_pkg::t_stat                          o_stat
);

    localparam int MB = rpa_pkg::MaskBits;
    localparam int TB = rpa_pkg::TopBits;
    localparam int CB = rpa_pkg::CountBits;
    localparam int RB = rpa_pkg::RegBits;
    localparam int AB = rpa_pkg::StackAddrBits;
    localparam int FB = rpa_pkg::FillBits;

    // configuration
    logic [MB-1:0] r_cfg_temp_mask, r_cfg_var_mask;

    // pool state
    logic [TB-1:0] r_temp_top, r_var_top, r_temp_size, r_var_size;
    logic [MB-1:0] r_temp_members, r_var_members, r_temp_free, r_var_free;
    logic [MB-1:0] r_temp_used, r_var_used, r_standin;
    logic [CB-1:0] r_temp_cnt, r_var_cnt;
    logic [FB-1:0] r_fill_cnt;

    rpa_pkg::t_req r_req;
    rpa_pkg::t_rsp r_rsp;

    // next values, taken on commit
    logic [TB-1:0] n_temp_top, n_var_top;
    logic [MB-1:0] n_temp_members, n_var_members, n_temp_free, n_var_free;
    logic [MB-1:0] n_temp_used, n_var_used, n_standin;
    logic [CB-1:0] n_temp_cnt, n_var_cnt;

    logic [2:0]    d_status;
    logic [RB-1:0] d_granted;
    logic          d_stolen;
    logic          temp_push, var_push;

    logic [RB-1:0] temp_rdata, var_rdata;
    logic [TB-1:0] temp_dec, var_dec;

    logic          temp_we, var_we;
    logic [AB-1:0] temp_waddr, var_waddr;
    logic [RB-1:0] temp_wdata, var_wdata;

    // ---------------- request decode and state update ----------------
    always_comb begin
        logic [MB-1:0] bit_r, temp_bit, var_bit, mem_t, mem_v;
        logic          in_range, temp_hit, var_hit, is_rel;

        bit_r    = MB'(1) << r_req.reg_num;
        temp_bit = MB'(1) << temp_rdata;
        var_bit  = MB'(1) << var_rdata;
        in_range = ({1'b0, r_req.reg_num} < (RB + 1)'(rpa_pkg::RegLimit));
        temp_hit = (r_temp_top < r_temp_size);
        var_hit  = (r_var_top < r_var_size);
        temp_dec = r_temp_top - TB'(1);
        var_dec  = r_var_top - TB'(1);
        is_rel   = 1'b0;
        mem_t    = r_temp_members;
        mem_v    = r_var_members;

        d_status       = rpa_pkg::ST_OK;
        d_granted      = '0;
        d_stolen       = 1'b0;
        temp_push      = 1'b0;
        var_push       = 1'b0;
        n_temp_top     = r_temp_top;
        n_var_top      = r_var_top;
        n_temp_members = r_temp_members;
        n_var_members  = r_var_members;
        n_temp_free    = r_temp_free;
        n_var_free     = r_var_free;
        n_temp_used    = r_temp_used;
        n_var_used     = r_var_used;
        n_standin      = r_standin;
        n_temp_cnt     = r_temp_cnt;
        n_var_cnt      = r_var_cnt;

        case (r_req.kind)
            rpa_pkg::KIND_ALLOC_TEMP: begin
                if (temp_hit) begin
                    d_granted   = temp_rdata;
                    n_temp_top  = r_temp_top + TB'(1);
                    n_temp_used = r_temp_used | temp_bit;
                    n_temp_free = r_temp_free & ~temp_bit;
                    n_temp_cnt  = r_temp_cnt + CB'(!(|(r_temp_used & temp_bit)));
                end else if (var_hit) begin
                    d_granted  = var_rdata;
                    d_stolen   = 1'b1;
                    n_var_top  = r_var_top + TB'(1);
                    n_var_used = r_var_used | var_bit;
                    n_var_free = r_var_free & ~var_bit;
                    n_var_cnt  = r_var_cnt + CB'(!(|(r_var_used & var_bit)));
                    n_standin  = r_standin | var_bit;
                end else begin
                    d_status = rpa_pkg::ST_NONE;
                end
            end
            rpa_pkg::KIND_ALLOC_VAR: begin
                if (var_hit) begin
                    d_granted  = var_rdata;
                    n_var_top  = r_var_top + TB'(1);
                    n_var_used = r_var_used | var_bit;
                    n_var_free = r_var_free & ~var_bit;
                    n_var_cnt  = r_var_cnt + CB'(!(|(r_var_used & var_bit)));
                end else begin
                    d_status = rpa_pkg::ST_NONE;
                end
            end
            rpa_pkg::KIND_RELEASE: begin
                is_rel = 1'b1;
            end
            rpa_pkg::KIND_RAW_ADD: begin
                is_rel = 1'b1;
                if (in_range) begin
                    if (r_req.target_pool) mem_v = r_var_members | bit_r;
                    else                   mem_t = r_temp_members | bit_r;
                end
            end
            rpa_pkg::KIND_RESTART: begin
                n_temp_members = r_cfg_temp_mask & rpa_pkg::LowMask;
                n_var_members  = r_cfg_var_mask & rpa_pkg::LowMask;
                n_temp_free    = r_cfg_temp_mask & rpa_pkg::LowMask;
                n_var_free     = r_cfg_var_mask & rpa_pkg::LowMask;
                n_temp_used    = '0;
                n_var_used     = '0;
                n_standin      = '0;
                n_temp_cnt     = '0;
                n_var_cnt      = '0;
                n_temp_top     = '0;
                n_var_top      = '0;
            end
            default: begin
                d_status = rpa_pkg::ST_OK;
            end
        endcase

        // release: temporary pool wins when a register sits in both
        if (is_rel) begin
            if (!in_range) begin
                d_status = rpa_pkg::ST_NOTMEM;
            end else if (|(mem_t & bit_r)) begin
                if (|(r_temp_free & bit_r)) begin
                    d_status = rpa_pkg::ST_FREE;
                end else if (r_temp_top == '0) begin
                    d_status = rpa_pkg::ST_OVERFLOW;
                end else begin
                    temp_push   = 1'b1;
                    n_temp_top  = temp_dec;
                    n_temp_free = r_temp_free | bit_r;
                end
            end else if (|(mem_v & bit_r)) begin
                if (|(r_var_free & bit_r)) begin
                    d_status = rpa_pkg::ST_FREE;
                end else if (r_var_top == '0) begin
                    d_status = rpa_pkg::ST_OVERFLOW;
                end else begin
                    var_push   = 1'b1;
                    n_var_top  = var_dec;
                    n_var_free = r_var_free | bit_r;
                end
            end else begin
                d_status = rpa_pkg::ST_NOTMEM;
            end
            // failed raw add leaves membership untouched
            if (d_status == rpa_pkg::ST_OK) begin
                n_temp_members = mem_t;
                n_var_members  = mem_v;
            end
        end
    end

    // ---------------- stack memories ----------------
    always_comb begin
        if (i_cmd.fill_step) begin
            temp_we    = r_temp_members[r_fill_cnt];
            var_we     = r_var_members[r_fill_cnt];
            temp_waddr = r_temp_size[AB-1:0];
            var_waddr  = r_var_size[AB-1:0];
            temp_wdata = RB'(r_fill_cnt);
            var_wdata  = RB'(r_fill_cnt);
        end else begin
            temp_we    = i_cmd.commit && temp_push;
            var_we     = i_cmd.commit && var_push;
            temp_waddr = temp_dec[AB-1:0];
            var_waddr  = var_dec[AB-1:0];
            temp_wdata = r_req.reg_num;
            var_wdata  = r_req.reg_num;
        end
    end

    rpa_ram #(
        .WIDTH (RB),
        .DEPTH (rpa_pkg::NumRegs)
    ) u_temp_stack (
        .i_clk   (i_clk),
        .i_we    (temp_we),
        .i_waddr (temp_waddr),
        .i_wdata (temp_wdata),
        .i_raddr (r_temp_top[AB-1:0]),
        .o_rdata (temp_rdata)
    );

    rpa_ram #(
        .WIDTH (RB),
        .DEPTH (rpa_pkg::NumRegs)
    ) u_var_stack (
        .i_clk   (i_clk),
        .i_we    (var_we),
        .i_waddr (var_waddr),
        .i_wdata (var_wdata),
        .i_raddr (r_var_top[AB-1:0]),
        .o_rdata (var_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp_mask <= '0;
            r_cfg_var_mask  <= '0;
            r_temp_top      <= '0;
            r_var_top       <= '0;
            r_temp_size     <= '0;
            r_var_size      <= '0;
            r_temp_members  <= '0;
            r_var_members   <= '0;
            r_temp_free     <= '0;
            r_var_free      <= '0;
            r_temp_used     <= '0;
            r_var_used      <= '0;
            r_standin       <= '0;
            r_temp_cnt      <= '0;
            r_var_cnt       <= '0;
            r_fill_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpa_pkg::CFG_TEMP_MEMBER_MASK: r_cfg_temp_mask <= i_cfg_wdata;
                    rpa_pkg::CFG_VAR_MEMBER_MASK:  r_cfg_var_mask  <= i_cfg_wdata;
                    default: r_cfg_temp_mask <= r_cfg_temp_mask;
                endcase
            end
            if (i_cmd.commit) begin
                r_temp_top     <= n_temp_top;
                r_var_top      <= n_var_top;
                r_temp_members <= n_temp_members;
                r_var_members  <= n_var_members;
                r_temp_free    <= n_temp_free;
                r_var_free     <= n_var_free;
                r_temp_used    <= n_temp_used;
                r_var_used     <= n_var_used;
                r_standin      <= n_standin;
                r_temp_cnt     <= n_temp_cnt;
                r_var_cnt      <= n_var_cnt;
                if (o_stat.is_restart) begin
                    r_temp_size <= '0;
                    r_var_size  <= '0;
                    r_fill_cnt  <= '0;
                end
            end else if (i_cmd.fill_step) begin
                r_fill_cnt <= r_fill_cnt + FB'(1);
                if (r_temp_members[r_fill_cnt]) r_temp_size <= r_temp_size + TB'(1);
                if (r_var_members[r_fill_cnt])  r_var_size  <= r_var_size + TB'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.load_out) begin
            r_rsp.status          <= d_status;
            r_rsp.granted_reg     <= d_granted;
            r_rsp.stolen          <= d_stolen;
            r_rsp.temp_used_mask  <= n_temp_used;
            r_rsp.var_used_mask   <= n_var_used;
            r_rsp.standin_mask    <= n_standin;
            r_rsp.temp_used_count <= n_temp_cnt;
            r_rsp.var_used_count  <= n_var_cnt;
        end
    end

    assign o_rsp             = r_rsp;
    assign o_stat.is_restart = (r_req.kind == rpa_pkg::KIND_RESTART);
    assign o_stat.fill_last  = (r_fill_cnt == FB'(rpa_pkg::RegLimit - 1));

    `RPA_ASSERT_ALWAYS(a_top_within_size, i_clk, i_rst_n,
        (r_temp_top <= r_temp_size) && (r_var_top <= r_var_size),
        "stack top ran past the filled entries")
    `RPA_ASSERT_ALWAYS(a_free_are_members, i_clk, i_rst_n,
        ((r_temp_free & ~r_temp_members) == '0) && ((r_var_free & ~r_var_members) == '0),
        "free register outside its pool")
    `RPA_ASSERT_ALWAYS(a_standin_from_var_pool, i_clk, i_rst_n,
        (r_standin & ~r_var_members) == '0,
        "stand-in register is not a variable pool member")

endmodule

`default_nettype wire

/* hdl/register_pool_allocator.sv */
// Top level of the register pool allocator: controller plus datapath.
//
// Hands out registers of one 32-entry register file from two LIFO free
// stacks, temporaries and variables. An allocation or release is captured
// in the accept cycle and executed in the next unless the output register
// still holds an unread result, using the top-of-stack entry that the
// stack RAM has already read out (registered read, one RAM per pool). A
// restart runs accept, execute, then a sweep that walks the member masks
// one register a cycle to refill both stacks in ascending order, then the
// report state. A new request is taken only when the previous one is finished,
// but a result waiting in the output register does not hold off the next
// request; it only stalls completion of that next request. Write the member
// mask registers (index 0 temporaries, 1 variables) only while no request
// is in flight; they take effect at the next restart. Stack entries are
// never cleared; the pop pointer never reaches an entry that was not
// written.
`default_nettype none

module register_pool_allocator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_req_valid,
    output logic                                o_req_ready,
    input  wire rpa_pkg::t_req                  i_req,
    // response channel
    output logic                                o_rsp_valid,
    input  wire logic                           i_rsp_ready,
    output rpa_pkg::t_rsp                       o_rsp,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [rpa_pkg::CfgIdxBits-1:0] i_cfg_idx,
    input  wire logic [rpa_pkg::MaskBits-1:0]   i_cfg_wdata
);

    rpa_pkg::t_cmd  cmd;
    rpa_pkg::t_stat stat;

    // sequencing: idle -> execute -> (fill sweep -> report) -> idle
    rpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // pool state, stack RAMs, config registers and result register
    rpa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

/* test/register_pool_allocator_tb.sv */
// Self-checking testbench for the register pool allocator.
`timescale 1ns / 1ps

module register_pool_allocator_tb;

    import rpa_pkg::*;

    localparam int POOL_TEMP   = 0;
    localparam int POOL_VAR    = 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req       = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_we    = 1'b0;
    logic [CfgIdxBits-1:0] i_cfg_idx   = '0;
    logic [MaskBits-1:0]   i_cfg_wdata = '0;

    register_pool_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the allocator: member-mask registers, both free stacks
    // and the accumulated masks. Index 0 is the temporary pool, 1 the
    // variable pool.
    // ------------------------------------------------------------------
    logic [MaskBits-1:0] cfg_member   [2];
    logic [RegBits-1:0]  free_stack   [2][NumRegs];
    int                  stack_top    [2];
    int                  stack_fill   [2];
    logic [MaskBits-1:0] pool_member  [2];
    logic [MaskBits-1:0] pool_free    [2];
    logic [MaskBits-1:0] pool_used    [2];
    logic [MaskBits-1:0] standin_bits;

    t_req pending_requests    [$];
    t_rsp predicted_responses [$];

    int requests_queued   = 0;
    int requests_taken    = 0;
    int responses_checked = 0;
    int mismatches        = 0;
    int restarts_queued   = 0;
    int stolen_grants     = 0;
    int mask_settings     = 0;
    int status_seen [5]   = '{default: 0};
    int cycle_count       = 0;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;

    // Pop the next free register of a pool; -1 when the pool is exhausted.
    function automatic int pool_take(int p);
        int r;
        if (stack_top[p] >= stack_fill[p] || stack_top[p] >= NumRegs)
            return -1;
        r = free_stack[p][stack_top[p]];
        stack_top[p]++;
        pool_used[p][r] = 1'b1;
        pool_free[p][r] = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] pool_give(int p, logic [RegBits-1:0] r);
        if (stack_top[p] == 0 || stack_top[p] > NumRegs)
            return ST_OVERFLOW;
        stack_top[p]--;
        free_stack[p][stack_top[p]] = r;
        pool_free[p][r] = 1'b1;
        return ST_OK;
    endfunction

    // A register in both pools goes back to the temporary pool;
    // stand-ins go back to the variable pool they came from.
    function automatic logic [2:0] give_back(logic [RegBits-1:0] r);
        if (r >= RegLimit)
            return ST_NOTMEM;
        if (pool_member[POOL_TEMP][r])
            return pool_free[POOL_TEMP][r] ? ST_FREE : pool_give(POOL_TEMP, r);
        if (pool_member[POOL_VAR][r])
            return pool_free[POOL_VAR][r] ? ST_FREE : pool_give(POOL_VAR, r);
        return ST_NOTMEM;
    endfunction

    function automatic t_rsp pool_response_for(t_req rq);
        t_rsp                rsp;
        int                  got;
        logic [MaskBits-1:0] saved_temp;
        logic [MaskBits-1:0] saved_var;
        rsp = '0;
        rsp.status = ST_OK;
        case (rq.kind)
            KIND_ALLOC_TEMP: begin
                got = pool_take(POOL_TEMP);
                if (got >= 0) begin
                    rsp.granted_reg = got[RegBits-1:0];
                end else begin
                    // temporaries exhausted: borrow a variable register
                    got = pool_take(POOL_VAR);
                    if (got >= 0) begin
                        rsp.granted_reg   = got[RegBits-1:0];
                        rsp.stolen        = 1'b1;
                        standin_bits[got] = 1'b1;
                    end else begin
                        rsp.status = ST_NONE;
                    end
                end
            end
            KIND_ALLOC_VAR: begin
                got = pool_take(POOL_VAR);
                if (got >= 0)
                    rsp.granted_reg = got[RegBits-1:0];
                else
                    rsp.status = ST_NONE;
            end
            KIND_RELEASE: begin
                rsp.status = give_back(rq.reg_num);
            end
            KIND_RESTART: begin
                for (int p = 0; p < 2; p++) begin
                    pool_member[p] = cfg_member[p] & LowMask;
                    pool_free[p]   = pool_member[p];
                    pool_used[p]   = '0;
                    stack_fill[p]  = 0;
                    stack_top[p]   = 0;
                    for (int i = 0; i < RegLimit; i++) begin
                        if (pool_member[p][i]) begin
                            free_stack[p][stack_fill[p]] = i[RegBits-1:0];
                            stack_fill[p]++;
                        end
                    end
                end
                standin_bits = '0;
            end
            KIND_RAW_ADD: begin
                saved_temp = pool_member[POOL_TEMP];
                saved_var  = pool_member[POOL_VAR];
                if (rq.reg_num < RegLimit)
                    pool_member[rq.target_pool][rq.reg_num] = 1'b1;
                rsp.status = give_back(rq.reg_num);
                // a failed add leaves membership as it was
                if (rsp.status != ST_OK) begin
                    pool_member[POOL_TEMP] = saved_temp;
                    pool_member[POOL_VAR]  = saved_var;
                end
            end
            default: ;
        endcase
        rsp.temp_used_mask  = pool_used[POOL_TEMP];
        rsp.var_used_mask   = pool_used[POOL_VAR];
        rsp.standin_mask    = standin_bits;
        rsp.temp_used_count = CountBits'($countones(pool_used[POOL_TEMP]));
        rsp.var_used_count  = CountBits'($countones(pool_used[POOL_VAR]));
        return rsp;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: one request per handshake, valid held until taken.
    // The expectation is computed at the edge that accepts the request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                predicted_responses.push_back(pool_response_for(i_req));
                requests_taken++;
            end
            if (!i_req_valid || o_req_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_req       <= pending_requests.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_response(t_rsp got);
        t_rsp want;
        if (predicted_responses.size() == 0) begin
            $display("%0t: response with none outstanding, expected nothing, actual %h",
                     $time, got);
            mismatches++;
        end else begin
            want = predicted_responses.pop_front();
            check_field("status", want.status, got.status);
            check_field("granted_reg", want.granted_reg, got.granted_reg);
            check_field("stolen", want.stolen, got.stolen);
            check_field("temp_used_mask", want.temp_used_mask, got.temp_used_mask);
            check_field("var_used_mask", want.var_used_mask, got.var_used_mask);
            check_field("standin_mask", want.standin_mask, got.standin_mask);
            check_field("temp_used_count", want.temp_used_count, got.temp_used_count);
            check_field("var_used_count", want.var_used_count, got.var_used_count);
            if (want.status <= ST_OVERFLOW)
                status_seen[want.status]++;
            if (want.stolen)
                stolen_grants++;
            responses_checked++;
        end
    endtask

    // Response monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready)
                check_response(o_rsp);
            i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d of %0d requests answered",
                     cycle_count, responses_checked, requests_queued);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic enqueue(logic [2:0] kind, logic [RegBits-1:0] r, logic pool);
        t_req rq;
        rq.kind        = kind;
        rq.reg_num     = r;
        rq.target_pool = pool;
        pending_requests.push_back(rq);
        requests_queued++;
        if (kind == KIND_RESTART)
            restarts_queued++;
    endtask

    task automatic wait_for_drain();
        while (requests_taken != requests_queued || predicted_responses.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_member_masks(logic [MaskBits-1:0] tmask,
                                      logic [MaskBits-1:0] vmask);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TEMP_MEMBER_MASK;
        i_cfg_wdata <= tmask;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_VAR_MEMBER_MASK;
        i_cfg_wdata <= vmask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_member[POOL_TEMP] = tmask;
        cfg_member[POOL_VAR]  = vmask;
        mask_settings++;
    endtask

    // Mostly a member of either pool, leaning toward the low members that
    // a fresh stack hands out first.
    function automatic logic [RegBits-1:0] pick_member(logic [MaskBits-1:0] m);
        int cnt;
        int k;
        cnt = $countones(m);
        if (cnt == 0)
            return RegBits'($urandom);
        k = $urandom_range(1) ? $urandom_range(cnt - 1)
                              : $urandom_range(((cnt < 6) ? cnt : 6) - 1);
        for (int i = 0; i < MaskBits; i++) begin
            if (m[i]) begin
                if (k == 0)
                    return i[RegBits-1:0];
                k--;
            end
        end
        return '0;
    endfunction

    task automatic enqueue_random();
        int                  pick;
        logic [RegBits-1:0]  r;
        logic [MaskBits-1:0] members;
        pick    = $urandom_range(99);
        members = cfg_member[POOL_TEMP] | cfg_member[POOL_VAR];
        r       = ($urandom_range(3) != 0) ? pick_member(members) : RegBits'($urandom);
        if (pick < 30)
            enqueue(KIND_ALLOC_TEMP, RegBits'($urandom), 1'($urandom));
        else if (pick < 48)
            enqueue(KIND_ALLOC_VAR, RegBits'($urandom), 1'($urandom));
        else if (pick < 80)
            enqueue(KIND_RELEASE, r, 1'($urandom));
        else if (pick < 84)
            enqueue(KIND_RESTART, RegBits'($urandom), 1'($urandom));
        else if (pick < 97)
            enqueue(KIND_RAW_ADD, $urandom_range(1) ? r : RegBits'($urandom), 1'($urandom));
        else
            enqueue(3'($urandom_range(5, 7)), RegBits'($urandom), 1'($urandom));
    endtask

    // Each setting starts from a restart so the new masks take effect;
    // halfway through, the sender holds off until every response is back.
    task automatic run_random_phase(int count);
        enqueue(KIND_RESTART, '0, 1'b0);
        for (int i = 1; i < count; i++) begin
            if (i == count / 2)
                wait_for_drain();
            enqueue_random();
        end
        wait_for_drain();
    endtask

    logic [MaskBits-1:0] phase_temp [NUM_PHASES];
    logic [MaskBits-1:0] phase_var  [NUM_PHASES];
    int                  phase_len  [NUM_PHASES] = '{230, 230, 230, 60, 250, 250};

    initial begin
        cfg_member[POOL_TEMP] = '0;
        cfg_member[POOL_VAR]  = '0;
        for (int p = 0; p < 2; p++) begin
            stack_top[p]   = 0;
            stack_fill[p]  = 0;
            pool_member[p] = '0;
            pool_free[p]   = '0;
            pool_used[p]   = '0;
        end
        standin_bits = '0;

        phase_temp = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                       $urandom, $urandom & $urandom & $urandom};
        phase_var  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                       $urandom, $urandom & $urandom & $urandom};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 72;

        // Straight out of reset: no pool has members yet.
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);      // both pools empty
        enqueue(KIND_RELEASE, 5'd31, 1'b1);        // not a member
        enqueue(KIND_RAW_ADD, 5'd0, 1'b0);         // push onto a full stack, undone
        enqueue(3'd7, 5'd31, 1'b1);                // unused kind
        wait_for_drain();

        // Temporaries {0,1}, variables {1,2,31}: register 1 sits in both.
        write_member_masks(32'h0000_0003, 32'h8000_0006);
        enqueue(KIND_RESTART, 5'd0, 1'b0);
        enqueue(KIND_RELEASE, 5'd0, 1'b0);         // already free
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);      // stand-in from variables
        enqueue(KIND_RELEASE, 5'd1, 1'b0);         // dual member goes to temporaries
        enqueue(KIND_ALLOC_VAR, 5'd0, 1'b1);
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);      // stand-in 31
        enqueue(KIND_RELEASE, 5'd31, 1'b0);        // stand-in back to variables
        enqueue(KIND_ALLOC_TEMP, 5'd0, 1'b0);      // stand-in again
        enqueue(KIND_ALLOC_VAR, 5'd0, 1'b1);       // variables exhausted
        enqueue(KIND_RELEASE, 5'd0, 1'b0);
        enqueue(KIND_RAW_ADD, 5'd5, 1'b1);         // new variable member
        enqueue(KIND_RAW_ADD, 5'd5, 1'b0);         // now in both pools
        enqueue(KIND_RELEASE, 5'd3, 1'b0);         // not a member
        enqueue(3'd5, 5'd0, 1'b0);
        enqueue(3'd6, 5'd31, 1'b1);
        enqueue(KIND_RAW_ADD, 5'd9, 1'b0);         // temp stack full: undone
        enqueue(KIND_RESTART, 5'd31, 1'b1);
        enqueue(KIND_RELEASE, 5'd31, 1'b1);        // free variable
        enqueue(KIND_ALLOC_VAR, 5'd31, 1'b1);
        wait_for_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 72;
                recv_idle_pct = 21;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_member_masks(phase_temp[ph], phase_var[ph]);
            run_random_phase(phase_len[ph]);
        end

        wait_for_drain();
        repeat (40) @(posedge i_clk);

        $display("Checked %0d of %0d requests across %0d mask settings, %0d restarts, %0d stand-in grants",
                 responses_checked, requests_queued, mask_settings, restarts_queued,
                 stolen_grants);
        $display("Status mix: ok %0d, none left %0d, already free %0d, not member %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_FREE],
                 status_seen[ST_NOTMEM], status_seen[ST_OVERFLOW]);
        if (mismatches == 0 && predicted_responses.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches,
                     predicted_responses.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
